FILE: sv/qpsk_symbol_error_statistics_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the QPSK symbol error statistics unit.
// ----------------------------------------------------------------------------
`ifndef QPSK_SYMBOL_ERROR_STATISTICS_UNIT_MACROS_SVH
`define QPSK_SYMBOL_ERROR_STATISTICS_UNIT_MACROS_SVH

// Check a property outside reset.
`define QSES_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define QSES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/qses_pkg.sv
// ----------------------------------------------------------------------------
// qses_pkg
// Shared types, codes and sizes of the QPSK symbol error statistics unit.
// ----------------------------------------------------------------------------
package qses_pkg;

    // Field sizes
    localparam int SAMPLE_WIDTH    = 16;
    localparam int READ_WIDTH      = 48;
    localparam int CNT_WIDTH_DEF   = 48;
    localparam int FUNC_WIDTH      = 2;
    localparam int LABEL_WIDTH     = 2;
    localparam int DEC_WIDTH       = 3;
    localparam int INDEX_WIDTH     = 5;

    // Operation codes
    localparam logic [FUNC_WIDTH-1:0] FUNC_ACCUM = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR = 2'd2;

    // Decision codes
    localparam logic [DEC_WIDTH-1:0] DEC_SYM0   = 3'd0;
    localparam logic [DEC_WIDTH-1:0] DEC_SYM1   = 3'd1;
    localparam logic [DEC_WIDTH-1:0] DEC_SYM2   = 3'd2;
    localparam logic [DEC_WIDTH-1:0] DEC_SYM3   = 3'd3;
    localparam logic [DEC_WIDTH-1:0] DEC_ABSENT = 3'd4;

    // Counter map
    localparam int CELLS        = 20;
    localparam int CELL_IDX_W   = $clog2(CELLS);
    localparam logic [INDEX_WIDTH-1:0] IDX_TOTAL    = 5'd20;
    localparam logic [INDEX_WIDTH-1:0] IDX_OBSERVED = 5'd21;
    localparam logic [INDEX_WIDTH-1:0] IDX_SYM_ERR  = 5'd22;
    localparam logic [INDEX_WIDTH-1:0] IDX_BIT_ERR  = 5'd23;

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0]          func;
        logic [LABEL_WIDTH-1:0]         sent_label;
        logic signed [SAMPLE_WIDTH-1:0] in_phase;
        logic signed [SAMPLE_WIDTH-1:0] quadrature;
        logic                           present;
        logic [INDEX_WIDTH-1:0]         read_index;
    } sample_in_t;

    typedef struct packed {
        logic [DEC_WIDTH-1:0]  decision;
        logic                  symbol_error;
        logic [1:0]            bit_error_count;
        logic [READ_WIDTH-1:0] read_value;
    } result_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic [FUNC_WIDTH-1:0]  func;
        logic [INDEX_WIDTH-1:0] addr;
        logic                   present;
        logic [DEC_WIDTH-1:0]   decision;
        logic                   symbol_error;
        logic [1:0]             bit_error_count;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: sv/qses_front.sv
// ----------------------------------------------------------------------------
// qses_front
// Accepts input items, makes the hard decision and Gray bit error count,
// and pushes one classified operation into the queue.
// ----------------------------------------------------------------------------
module qses_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  qses_pkg::sample_in_t  s_data,
    input  qses_pkg::queue_status_t q_status,
    output logic                  push,
    output qses_pkg::queue_entry_t push_entry
);
    import qses_pkg::*;

    logic signed [SAMPLE_WIDTH:0] x_ext;
    logic signed [SAMPLE_WIDTH:0] p_ext;
    logic [SAMPLE_WIDTH:0]        x_mag;
    logic [SAMPLE_WIDTH:0]        p_mag;
    logic [DEC_WIDTH-1:0]         hard_dec;
    logic [DEC_WIDTH-1:0]         dec;
    logic [LABEL_WIDTH-1:0]       gray_diff;
    logic [CELL_IDX_W-1:0]        cell_idx;

    // Take an item whenever the queue has room
    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    // Magnitudes with one extra bit so the most negative value fits
    assign x_ext = {s_data.in_phase[SAMPLE_WIDTH-1], s_data.in_phase};
    assign p_ext = {s_data.quadrature[SAMPLE_WIDTH-1], s_data.quadrature};
    assign x_mag = x_ext[SAMPLE_WIDTH] ? $unsigned(-x_ext) : $unsigned(x_ext);
    assign p_mag = p_ext[SAMPLE_WIDTH] ? $unsigned(-p_ext) : $unsigned(p_ext);

    // Larger magnitude picks the axis, its sign picks the symbol
    always_comb begin
        if (x_mag >= p_mag) begin
            hard_dec = x_ext[SAMPLE_WIDTH] ? DEC_SYM2 : DEC_SYM0;
        end else begin
            hard_dec = p_ext[SAMPLE_WIDTH] ? DEC_SYM3 : DEC_SYM1;
        end
    end

    assign dec       = s_data.present ? hard_dec : DEC_ABSENT;
    assign gray_diff = (s_data.sent_label ^ (s_data.sent_label >> 1))
                     ^ (hard_dec[LABEL_WIDTH-1:0] ^ (hard_dec[LABEL_WIDTH-1:0] >> 1));
    // label * 5 + decision
    assign cell_idx  = CELL_IDX_W'({s_data.sent_label, 2'b00})
                     + CELL_IDX_W'(s_data.sent_label) + CELL_IDX_W'(dec);

    // Build the queue entry; non-accumulate items carry zero sample fields
    always_comb begin
        push_entry                 = '0;
        push_entry.func            = s_data.func;
        push_entry.addr            = s_data.read_index;
        if (s_data.func == FUNC_ACCUM) begin
            push_entry.addr         = INDEX_WIDTH'(cell_idx);
            push_entry.present      = s_data.present;
            push_entry.decision     = dec;
            if (s_data.present) begin
                push_entry.symbol_error    =
                    (hard_dec != {1'b0, s_data.sent_label});
                push_entry.bit_error_count =
                    {1'b0, gray_diff[0]} + {1'b0, gray_diff[1]};
            end
        end
    end

endmodule

FILE: sv/qses_queue.sv
// ----------------------------------------------------------------------------
// qses_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module qses_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  qses_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output qses_pkg::queue_entry_t  pop_entry,
    output qses_pkg::queue_status_t status
);
    import qses_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = slot_reg[rd_ptr_reg];

    // Advance pointers, wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/qses_back.sv
// ----------------------------------------------------------------------------
// qses_back
// Carries out queued operations on the counters and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module qses_back #(
    parameter int COUNT_WIDTH = qses_pkg::CNT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  qses_pkg::queue_status_t q_status,
    input  qses_pkg::queue_entry_t  pop_entry,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output qses_pkg::result_t       m_data
);
    import qses_pkg::*;

    logic [COUNT_WIDTH-1:0] cell_cnt_reg [CELLS];
    logic [CELLS-1:0]       cell_vld_reg;
    logic [CELLS-1:0]       cell_vld_next;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic [COUNT_WIDTH-1:0] observed_reg;
    logic [COUNT_WIDTH-1:0] observed_next;
    logic [COUNT_WIDTH-1:0] sym_err_reg;
    logic [COUNT_WIDTH-1:0] sym_err_next;
    logic [COUNT_WIDTH-1:0] bit_err_reg;
    logic [COUNT_WIDTH-1:0] bit_err_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    result_t                m_data_reg;
    result_t                m_data_next;

    logic                   is_cell;
    logic [CELL_IDX_W-1:0]  cell_idx;
    logic [COUNT_WIDTH-1:0] cell_cur;
    logic [COUNT_WIDTH-1:0] cell_inc;
    logic                   cell_wr;
    logic [COUNT_WIDTH-1:0] sel_cnt;
    logic [READ_WIDTH-1:0]  sel_read;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] c,
        input logic [1:0]             n
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, c} + {{(COUNT_WIDTH - 1){1'b0}}, n};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    // Run one operation per cycle while the output register can take it
    assign pop     = !q_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Single cell read port, shared by accumulate and read
    assign is_cell  = (pop_entry.addr < INDEX_WIDTH'(CELLS));
    assign cell_idx = pop_entry.addr[CELL_IDX_W-1:0];
    assign cell_cur = (is_cell && cell_vld_reg[cell_idx]) ? cell_cnt_reg[cell_idx] : '0;
    assign cell_inc = sat_add(cell_cur, 2'd1);
    assign cell_wr  = pop && (pop_entry.func == FUNC_ACCUM) && is_cell;

    // Select the counter for a read
    always_comb begin
        sel_cnt = '0;
        if (is_cell) begin
            sel_cnt = cell_cur;
        end else begin
            case (pop_entry.addr)
                IDX_TOTAL:    sel_cnt = total_reg;
                IDX_OBSERVED: sel_cnt = observed_reg;
                IDX_SYM_ERR:  sel_cnt = sym_err_reg;
                IDX_BIT_ERR:  sel_cnt = bit_err_reg;
                default:      sel_cnt = '0;
            endcase
        end
    end

    // Fit the counter to the read port width
    generate
        if (COUNT_WIDTH >= READ_WIDTH) begin : g_trunc
            assign sel_read = sel_cnt[READ_WIDTH-1:0];
        end else begin : g_ext
            assign sel_read = {{(READ_WIDTH - COUNT_WIDTH){1'b0}}, sel_cnt};
        end
    endgenerate

    // Update counters and build the result
    always_comb begin
        cell_vld_next = cell_vld_reg;
        total_next    = total_reg;
        observed_next = observed_reg;
        sym_err_next  = sym_err_reg;
        bit_err_next  = bit_err_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            case (pop_entry.func)
                FUNC_ACCUM: begin
                    m_data_next.decision        = pop_entry.decision;
                    m_data_next.symbol_error    = pop_entry.symbol_error;
                    m_data_next.bit_error_count = pop_entry.bit_error_count;
                    if (cell_wr) begin
                        cell_vld_next[cell_idx] = 1'b1;
                    end
                    total_next    = sat_add(total_reg, 2'd1);
                    observed_next = sat_add(observed_reg, {1'b0, pop_entry.present});
                    sym_err_next  = sat_add(sym_err_reg, {1'b0, pop_entry.symbol_error});
                    bit_err_next  = sat_add(bit_err_reg, pop_entry.bit_error_count);
                end
                FUNC_READ: begin
                    m_data_next.read_value = sel_read;
                end
                FUNC_CLEAR: begin
                    cell_vld_next = '0;
                    total_next    = '0;
                    observed_next = '0;
                    sym_err_next  = '0;
                    bit_err_next  = '0;
                end
                default: begin
                    m_data_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= '0;
            total_reg    <= '0;
            observed_reg <= '0;
            sym_err_reg  <= '0;
            bit_err_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cell_vld_reg <= cell_vld_next;
            total_reg    <= total_next;
            observed_reg <= observed_next;
            sym_err_reg  <= sym_err_next;
            bit_err_reg  <= bit_err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (cell_wr) begin
            cell_cnt_reg[cell_idx] <= cell_inc;
        end
    end

endmodule

FILE: sv/qpsk_symbol_error_statistics_unit.sv
// ----------------------------------------------------------------------------
// qpsk_symbol_error_statistics_unit
// QPSK hard decision with confusion matrix and saturating error counters.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the queue, then its result is
// registered in the back stage output register.
// Throughput: one item per cycle while the result output is not stalled,
// set by the read-modify-write of the counters in the back stage.
// Reset: all counters read zero, the queue is empty, no result is pending.
// ----------------------------------------------------------------------------
module qpsk_symbol_error_statistics_unit #(
    parameter int COUNT_WIDTH = qses_pkg::CNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qses_pkg::sample_in_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qses_pkg::result_t    m_data
);
    import qses_pkg::*;

    queue_status_t q_status;
    queue_entry_t  push_entry;
    queue_entry_t  pop_entry;
    logic          push;
    logic          pop;

    // Classify incoming items
    qses_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple front and back
    qses_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Update counters and drive results
    qses_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: sv/qses_checker.sv
// ----------------------------------------------------------------------------
// qses_checker
// Port-level checks of the statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "qpsk_symbol_error_statistics_unit_macros.svh"

module qses_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input qses_pkg::sample_in_t s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input qses_pkg::result_t    m_data
);
    import qses_pkg::*;

    // No result directly out of reset
    `QSES_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A waiting input transfer holds
    `QSES_ASSERT(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_data), "stalled input changed")

    // A stalled result holds
    `QSES_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    // Bit errors only come with a symbol error
    `QSES_ASSERT(a_bit_sym, aclk, aresetn, m_valid && (m_data.bit_error_count != 2'd0) |-> m_data.symbol_error, "bit errors without symbol error")

    // Absent samples carry no errors and decisions stay in range
    `QSES_ASSERT(a_absent, aclk, aresetn, m_valid |-> (m_data.decision <= DEC_ABSENT) && (m_data.decision != DEC_ABSENT || (!m_data.symbol_error && m_data.bit_error_count == 2'd0)), "bad decision or error on absent sample")

endmodule

bind qpsk_symbol_error_statistics_unit qses_checker u_qses_checker (.*);
